// ===== src/ssca_pkg.sv =====
`default_nettype none

package ssca_pkg;

    localparam int NUM_CLASSES  = 10;
    localparam int CLASS_W      = 4;
    localparam int ADDR_W       = 48;
    localparam int SIZE_W       = 16;
    localparam int SLAB_SHIFT   = 12;
    localparam int REGION_SHIFT = 20;
    localparam int SLAB_SLOT_W  = 9;
    localparam int SLAB_NUM_W   = 8;
    localparam int LEFT_W       = 10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_NO_REGION = 2'd2;
    localparam logic [1:0] STATUS_BAD_FREE  = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Smallest class whose slot size covers the request; size is below 4096.
    function automatic logic [CLASS_W-1:0] class_of(input logic [SLAB_SHIFT-1:0] size);
        logic [CLASS_W-1:0] cls;
        cls = '0;
        for (int c = 0; c < NUM_CLASSES - 1; c++) begin
            if ((13'd8 << c) < {1'b0, size})
                cls = cls + 1'b1;
        end
        return cls;
    endfunction

    function automatic logic [LEFT_W-1:0] slots_per_slab(input logic [CLASS_W-1:0] cls);
        return LEFT_W'(10'd512 >> cls);
    endfunction

    function automatic logic [SLAB_SHIFT-1:0] slot_mask(input logic [CLASS_W-1:0] cls);
        logic [SLAB_SHIFT:0] m;
        m = (13'd8 << cls) - 13'd1;
        return m[SLAB_SHIFT-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/ssca_if.sv =====
`default_nettype none

interface ssca_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] request_size;
    logic [47:0] free_address;

    modport source (output valid, output cmd, output request_size, output free_address,
                    input ready);
    modport sink (input valid, input cmd, input request_size, input free_address,
                  output ready);
endinterface

interface ssca_rsp_if;
    logic        valid;
    logic        ready;
    logic [47:0] slot_address;
    logic [3:0]  size_class;
    logic [1:0]  status;

    modport source (output valid, output slot_address, output size_class, output status,
                    input ready);
    modport sink (input valid, input slot_address, input size_class, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== src/ssca_ram.sv =====
`default_nettype none

module ssca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/slab_size_class_allocator.sv =====
`default_nettype none

// Slab allocator with ten power-of-two size classes (8 to 4096 bytes) over up to
// MAX_REGIONS regions of 1 MB above heap_base. In the transfer cycle of a request the
// block reads the link memory (allocate) or the slab class memory (free), and in the
// next cycle it does the read-modify-write of the list heads and memories and loads
// the result register. A new request is taken once that result register is empty or
// is being drained. Slab assignment is tracked by the claim order (regions_used, next
// free slab), so neither memory needs a clearing pass after reset. Writes of heap_base
// must be made only while the block is idle; the block itself does not enforce this.
// The low 20 bits are dropped.
module slab_size_class_allocator #(
    parameter int MAX_REGIONS = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ssca_req_if.sink         req,
    ssca_rsp_if.source       rsp,
    input  wire logic        cfg_wr_en,
    input  wire logic [47:0] cfg_wr_data
);

    import ssca_pkg::*;

    localparam int REG_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RU_W       = $clog2(MAX_REGIONS + 1);
    localparam int GSLAB_W    = REG_W + SLAB_NUM_W;
    localparam int SLOT_W     = GSLAB_W + SLAB_SLOT_W;
    localparam int LINK_DEPTH = MAX_REGIONS * (1 << (SLAB_NUM_W + SLAB_SLOT_W));
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int SLAB_DEPTH = MAX_REGIONS * (1 << SLAB_NUM_W);
    localparam int SLAB_AW    = $clog2(SLAB_DEPTH);
    localparam int HI_W       = ADDR_W - REGION_SHIFT;

    state_t state_reg, state_next;

    logic [HI_W-1:0]       heap_hi_reg;
    logic                  head_valid_reg [NUM_CLASSES];
    logic [SLOT_W-1:0]     class_head_reg [NUM_CLASSES];
    logic [GSLAB_W-1:0]    fresh_num_reg  [NUM_CLASSES];
    logic [LEFT_W-1:0]     fresh_left_reg [NUM_CLASSES];
    logic [RU_W-1:0]       ru_reg, ru_next;
    logic [SLAB_NUM_W-1:0] nfs_reg, nfs_next;

    logic                  cmd_reg;
    logic                  big_reg;
    logic [CLASS_W-1:0]    cls_reg;
    logic [ADDR_W-1:0]     off_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [CLASS_W-1:0]    out_cls_reg, out_cls_next;
    logic [1:0]            out_status_reg, out_status_next;

    logic                  in_ready;
    logic                  in_xfer;
    logic [CLASS_W-1:0]    cls_in;
    logic [ADDR_W-1:0]     off_in;

    logic                  link_we;
    logic [LINK_AW-1:0]    link_waddr;
    logic [SLOT_W:0]       link_wdata;
    logic [LINK_AW-1:0]    link_raddr;
    logic [SLOT_W:0]       link_rdata;

    logic                  slab_we;
    logic [SLAB_AW-1:0]    slab_waddr;
    logic [CLASS_W-1:0]    slab_wdata;
    logic [SLAB_AW-1:0]    slab_raddr;
    logic [CLASS_W-1:0]    slab_rdata;

    logic                  head_we;
    logic [CLASS_W-1:0]    head_idx;
    logic                  head_valid_wdata;
    logic [SLOT_W-1:0]     head_wdata;
    logic                  fresh_we;
    logic [GSLAB_W-1:0]    fresh_num_wdata;
    logic [LEFT_W-1:0]     fresh_left_wdata;

    logic [RU_W-1:0]       ru_new;
    logic [SLAB_NUM_W-1:0] nfs_base;
    logic [GSLAB_W-1:0]    gslab;
    logic [LEFT_W-1:0]     left_base;
    logic [LEFT_W-1:0]     left_new;
    logic [SLAB_SLOT_W-1:0] slot_lo;
    logic [SLOT_W-1:0]     slot;
    logic [REG_W-1:0]      last_region;
    logic                  in_range;
    logic                  unassigned;
    logic                  misaligned;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign in_xfer   = req.valid && in_ready;
    assign req.ready = in_ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.slot_address = out_addr_reg;
    assign rsp.size_class   = out_cls_reg;
    assign rsp.status       = out_status_reg;

    // Issue the memory reads straight from the request so they land in the next cycle.
    assign cls_in     = class_of(req.request_size[SLAB_SHIFT-1:0]);
    assign off_in     = req.free_address - {heap_hi_reg, REGION_SHIFT'(0)};
    assign link_raddr = class_head_reg[cls_in][LINK_AW-1:0];
    assign slab_raddr = off_in[SLAB_SHIFT +: SLAB_AW];

    ssca_ram #(
        .WIDTH (SLOT_W + 1),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ssca_ram #(
        .WIDTH (CLASS_W),
        .DEPTH (SLAB_DEPTH)
    ) u_slab_ram (
        .clk   (clk),
        .we    (slab_we),
        .waddr (slab_waddr),
        .wdata (slab_wdata),
        .raddr (slab_raddr),
        .rdata (slab_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        ru_next          = ru_reg;
        nfs_next         = nfs_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_addr_next    = out_addr_reg;
        out_cls_next     = out_cls_reg;
        out_status_next  = out_status_reg;
        link_we          = 1'b0;
        link_waddr       = off_reg[3 +: LINK_AW];
        link_wdata       = '0;
        slab_we          = 1'b0;
        slab_waddr       = '0;
        slab_wdata       = cls_reg;
        head_we          = 1'b0;
        head_idx         = cls_reg;
        head_valid_wdata = 1'b0;
        head_wdata       = '0;
        fresh_we         = 1'b0;
        fresh_num_wdata  = fresh_num_reg[cls_reg];
        fresh_left_wdata = '0;

        // Fresh-slab path: claim a new slab when the current one is used up.
        ru_new    = (nfs_reg == '0) ? ru_reg + 1'b1 : ru_reg;
        nfs_base  = (nfs_reg == '0) ? {SLAB_NUM_W{1'b1}} : nfs_reg;
        gslab     = {REG_W'(ru_new - 1'b1), nfs_base};
        left_base = (fresh_left_reg[cls_reg] == '0) ? slots_per_slab(cls_reg)
                                                    : fresh_left_reg[cls_reg];
        left_new  = left_base - 1'b1;
        slot_lo   = left_new[SLAB_SLOT_W-1:0] << cls_reg;
        slot      = {((fresh_left_reg[cls_reg] == '0) ? gslab : fresh_num_reg[cls_reg]),
                     slot_lo};

        // Free checks: inside an opened region, not a header, already claimed, aligned.
        last_region = REG_W'(ru_reg - 1'b1);
        in_range    = off_reg[ADDR_W-1:REGION_SHIFT] < HI_W'(ru_reg);
        unassigned  = (off_reg[SLAB_SHIFT +: SLAB_NUM_W] == '0) ||
                      ((off_reg[REGION_SHIFT +: REG_W] == last_region) &&
                       (off_reg[SLAB_SHIFT +: SLAB_NUM_W] <= nfs_reg));
        misaligned  = (off_reg[SLAB_SHIFT-1:0] & slot_mask(slab_rdata)) != '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next      = ST_IDLE;
                out_valid_next  = 1'b1;
                out_addr_next   = '0;
                out_cls_next    = '0;
                out_status_next = STATUS_OK;
                if (cmd_reg == CMD_ALLOC) begin
                    if (big_reg) begin
                        out_status_next = STATUS_TOO_LARGE;
                    end else if (head_valid_reg[cls_reg]) begin
                        // Pop the list head.
                        head_we          = 1'b1;
                        head_valid_wdata = link_rdata[SLOT_W];
                        head_wdata       = link_rdata[SLOT_W-1:0];
                        out_cls_next     = cls_reg;
                        out_addr_next    = {heap_hi_reg, REGION_SHIFT'(0)} +
                                           ADDR_W'({class_head_reg[cls_reg], 3'b000});
                    end else if ((fresh_left_reg[cls_reg] == '0) && (nfs_reg == '0) &&
                                 (ru_reg >= RU_W'(MAX_REGIONS))) begin
                        out_status_next = STATUS_NO_REGION;
                        out_cls_next    = cls_reg;
                    end else begin
                        if (fresh_left_reg[cls_reg] == '0) begin
                            ru_next         = ru_new;
                            nfs_next        = nfs_base - 1'b1;
                            slab_we         = 1'b1;
                            slab_waddr      = gslab[SLAB_AW-1:0];
                            fresh_num_wdata = gslab;
                        end
                        fresh_we         = 1'b1;
                        fresh_left_wdata = left_new;
                        out_cls_next     = cls_reg;
                        out_addr_next    = {heap_hi_reg, REGION_SHIFT'(0)} +
                                           ADDR_W'({slot, 3'b000});
                    end
                end else begin
                    if (!in_range || unassigned || misaligned) begin
                        out_status_next = STATUS_BAD_FREE;
                    end else begin
                        // Push the slot onto its class list.
                        head_idx         = slab_rdata;
                        link_we          = 1'b1;
                        link_wdata       = {head_valid_reg[slab_rdata],
                                            class_head_reg[slab_rdata]};
                        head_we          = 1'b1;
                        head_valid_wdata = 1'b1;
                        head_wdata       = off_reg[3 +: SLOT_W];
                        out_cls_next     = slab_rdata;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            heap_hi_reg   <= '0;
            ru_reg        <= '0;
            nfs_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_valid_reg[c] <= 1'b0;
                fresh_left_reg[c] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            ru_reg        <= ru_next;
            nfs_reg       <= nfs_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                heap_hi_reg <= cfg_wr_data[ADDR_W-1:REGION_SHIFT];
            if (head_we)
                head_valid_reg[head_idx] <= head_valid_wdata;
            if (fresh_we)
                fresh_left_reg[cls_reg] <= fresh_left_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            cmd_reg <= req.cmd;
            big_reg <= req.request_size[SIZE_W-1:SLAB_SHIFT] != '0;
            cls_reg <= cls_in;
            off_reg <= off_in;
        end
        if (head_we)
            class_head_reg[head_idx] <= head_wdata;
        if (fresh_we)
            fresh_num_reg[cls_reg] <= fresh_num_wdata;
        out_addr_reg   <= out_addr_next;
        out_cls_reg    <= out_cls_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire
